// ===== sv/ttmc_pkg.sv =====
`timescale 1ns / 1ps
package ttmc_pkg;

    localparam int ADC_BITS        = 12;
    localparam int DUTY_WRAP       = 6249;
    localparam int DEBOUNCE_TICKS  = 25;
    localparam int HISTORY_DEPTH   = 8;

    localparam int DUTY_W          = 13;
    localparam int CUR_W           = 16;
    localparam int DB_W            = 5;
    localparam int IN_W            = 32;
    localparam int OUT_W           = 56;
    localparam int ADDR_W          = 5;

    localparam int DUTY_MIN_DITHER = (DUTY_WRAP * 3) / 10;
    localparam int SOFT_K          = 5 * DUTY_WRAP;
    localparam longint NUM_K       = 64'd1408000;
    localparam int DEN_K           = 111 * (1 << ADC_BITS);

    localparam int DIV_N_W         = 48;
    localparam int DIV_D_W         = 32;
    localparam int DIV_Q_W         = 17;

    localparam logic [2:0] MODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_START    = 3'd1;
    localparam logic [2:0] MODE_RUN      = 3'd2;
    localparam logic [2:0] MODE_DITHER   = 3'd3;
    localparam logic [2:0] MODE_STOPPING = 3'd4;
    localparam logic [2:0] MODE_STOPPED  = 3'd5;
    localparam logic [2:0] MODE_FAULT    = 3'd6;

    localparam logic [2:0] TRIP_NONE     = 3'd0;
    localparam logic [2:0] TRIP_HARD     = 3'd1;
    localparam logic [2:0] TRIP_OVER     = 3'd2;
    localparam logic [2:0] TRIP_SLOPE    = 3'd3;
    localparam logic [2:0] TRIP_DRIVER   = 3'd4;

    localparam logic [2:0] REG_THRESHOLD_MIN = 3'd0;
    localparam logic [2:0] REG_THRESHOLD_MAX = 3'd1;
    localparam logic [2:0] REG_HARD_LIMIT    = 3'd2;
    localparam logic [2:0] REG_SLOPE_TRIP    = 3'd3;
    localparam logic [2:0] REG_CONFIRM       = 3'd4;
    localparam logic [2:0] REG_SOFT_START    = 3'd5;
    localparam logic [2:0] REG_COOLDOWN      = 3'd6;
    localparam logic [2:0] REG_HOLDOFF       = 3'd7;

    typedef struct packed {
        logic [15:0] threshold_min;
        logic [15:0] threshold_max;
        logic [15:0] hard_limit;
        logic [15:0] slope_trip;
        logic [7:0]  confirm_ticks;
        logic [15:0] soft_start_ticks;
        logic [15:0] cooldown_ticks;
        logic [15:0] fault_holdoff_ticks;
    } ttmc_cfg_t;

endpackage

// ===== sv/torque_trip_motor_controller.sv =====
`timescale 1ns / 1ps
// Torque-trip motor controller, one input beat per 1 ms control tick. Each beat
// debounces the trigger and direction buttons, estimates motor current from the
// sense count over the applied duty, filters it, and steps the idle / soft-start /
// run / dither / brake / stopped / fault sequence; it returns one result beat.
// A beat is accepted, then runs through the core states to result valid: one 17-step
// restoring divider is shared by the current estimate and by the ramp or dither
// duty, and each division holds it until done. Below 10 % duty the estimate is
// held and no estimate division runs. The block takes no new beat until the
// previous result has been taken. Currents are Q8.8 amps.
module torque_trip_motor_controller
    import ttmc_pkg::*;
#(
    parameter int HISTORY_DEPTH_P = HISTORY_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_tvalid,
    output logic              s_tready,
    // sense_counts[11:0], pot_counts[23:12], trigger_raw[24], cw_raw[25],
    // ccw_raw[26], fault_in[27]
    input  logic [IN_W-1:0]   s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // ctrl_state[2:0], duty_out[15:3], dir_out[16], awake_out[17],
    // trip_reason[20:18], current_est[36:21], threshold_now[52:37]
    output logic [OUT_W-1:0]  m_tdata
);

    ttmc_cfg_t  cfg_reg, cfg_next;
    logic       wr;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[4:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_THRESHOLD_MIN: cfg_next.threshold_min       = pwdata[15:0];
                REG_THRESHOLD_MAX: cfg_next.threshold_max       = pwdata[15:0];
                REG_HARD_LIMIT:    cfg_next.hard_limit          = pwdata[15:0];
                REG_SLOPE_TRIP:    cfg_next.slope_trip          = pwdata[15:0];
                REG_CONFIRM:       cfg_next.confirm_ticks       = pwdata[7:0];
                REG_SOFT_START:    cfg_next.soft_start_ticks    = pwdata[15:0];
                REG_COOLDOWN:      cfg_next.cooldown_ticks      = pwdata[15:0];
                REG_HOLDOFF:       cfg_next.fault_holdoff_ticks = pwdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_THRESHOLD_MIN: prdata = 32'(cfg_reg.threshold_min);
            REG_THRESHOLD_MAX: prdata = 32'(cfg_reg.threshold_max);
            REG_HARD_LIMIT:    prdata = 32'(cfg_reg.hard_limit);
            REG_SLOPE_TRIP:    prdata = 32'(cfg_reg.slope_trip);
            REG_CONFIRM:       prdata = 32'(cfg_reg.confirm_ticks);
            REG_SOFT_START:    prdata = 32'(cfg_reg.soft_start_ticks);
            REG_COOLDOWN:      prdata = 32'(cfg_reg.cooldown_ticks);
            REG_HOLDOFF:       prdata = 32'(cfg_reg.fault_holdoff_ticks);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_min       <= 16'd512;
            cfg_reg.threshold_max       <= 16'd2560;
            cfg_reg.hard_limit          <= 16'd3584;
            cfg_reg.slope_trip          <= 16'd1024;
            cfg_reg.confirm_ticks       <= 8'd5;
            cfg_reg.soft_start_ticks    <= 16'd200;
            cfg_reg.cooldown_ticks      <= 16'd300;
            cfg_reg.fault_holdoff_ticks <= 16'd150;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ttmc_core #(
        .HISTORY_DEPTH_P (HISTORY_DEPTH_P)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== sv/ttmc_div.sv =====
`timescale 1ns / 1ps
module ttmc_div
    import ttmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_Q_W-1:0] quotient
);

    logic [DIV_N_W-1:0] rem_reg, rem_next;
    logic [DIV_N_W-1:0] dsh_reg, dsh_next;
    logic [DIV_Q_W-1:0] q_reg, q_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic               fits;

    assign fits = rem_reg >= dsh_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = dividend;
            dsh_next = {divisor, {(DIV_Q_W-1){1'b0}}};
            q_next   = '0;
            cnt_next = 5'(DIV_Q_W - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[DIV_Q_W-2:0], fits};
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == 5'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== sv/ttmc_debounce.sv =====
`timescale 1ns / 1ps
module ttmc_debounce
    import ttmc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic tick,
    input  logic raw,
    output logic stable
);

    logic            last_reg, last_next;
    logic            stable_reg, stable_next;
    logic [DB_W-1:0] timer_reg, timer_next;

    always_comb
    begin
        last_next   = last_reg;
        timer_next  = timer_reg;
        stable_next = stable_reg;
        if (tick)
        begin
            if (raw != last_reg)
            begin
                last_next  = raw;
                timer_next = '0;
            end
            else if (timer_reg < DB_W'(DEBOUNCE_TICKS))
            begin
                timer_next = timer_reg + 1'b1;
            end
            if (timer_next >= DB_W'(DEBOUNCE_TICKS))
            begin
                stable_next = raw;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg   <= 1'b0;
            stable_reg <= 1'b0;
            timer_reg  <= '0;
        end
        else
        begin
            last_reg   <= last_next;
            stable_reg <= stable_next;
            timer_reg  <= timer_next;
        end
    end

    assign stable = stable_reg;

endmodule

// ===== sv/ttmc_core.sv =====
`timescale 1ns / 1ps
module ttmc_core
    import ttmc_pkg::*;
#(
    parameter int HISTORY_DEPTH_P = HISTORY_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  ttmc_cfg_t        cfg,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    localparam int POS_W = (HISTORY_DEPTH_P > 1) ? $clog2(HISTORY_DEPTH_P) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_DIV1   = 3'd2;
    localparam logic [2:0] ST_FILT   = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam logic [2:0] ST_DIV2   = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0]        st_reg, st_next;
    logic [24:0]       p1_reg, p1_next;
    logic [15:0]       ith_reg, ith_next;
    logic              flt_reg, flt_next;
    logic              hold_reg, hold_next;
    logic [2:0]        mode_reg, mode_next;
    logic [15:0]       filt_reg, filt_next;
    logic [15:0]       hist_reg [HISTORY_DEPTH_P];
    logic [15:0]       hist_next [HISTORY_DEPTH_P];
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        over_reg, over_next;
    logic [15:0]       hcnt_reg, hcnt_next;
    logic [15:0]       phase_reg, phase_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic              dirl_reg, dirl_next;
    logic              dirp_reg, dirp_next;
    logic [2:0]        reason_reg, reason_next;
    logic              fentry_reg, fentry_next;
    logic              mval_reg, mval_next;
    logic [OUT_W-1:0]  mdata_reg, mdata_next;

    logic               accept;
    logic [2:0]         stable;
    logic               bt;
    logic               div_start, div_done;
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;
    logic [DIV_Q_W-1:0] div_q;

    logic [11:0] sense, pot;
    logic        thr_up;
    logic [15:0] thr_diff;
    logic [27:0] thr_prod;
    logic [15:0] thr_step;
    logic [15:0] ith_calc;

    logic [DIV_Q_W-1:0] q_off;
    logic [15:0]        raw_est;
    logic [17:0]        filt_sum;

    logic [18:0] five_f, four_ith, three_ith;
    logic [15:0] gap;
    logic [21:0] fifty_gap, three_ith_w;
    logic [30:0] soft_num;
    logic [28:0] ramp_num;
    logic [15:0] pt_inc, hcnt_inc;
    logic [7:0]  over_inc, over_new;
    logic [17:0] slope_diff;
    logic        slope_hit;
    logic        dp;
    logic        do_soft;
    logic        awake;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (st_reg == ST_IDLE) && !mval_reg;
    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign bt = stable[0];

    genvar g;
    for (g = 0; g < 3; g++)
    begin : g_btn
        ttmc_debounce u_db (
            .clk    (clk),
            .rst_n  (rst_n),
            .tick   (accept),
            .raw    (s_tdata[24+g]),
            .stable (stable[g])
        );
    end

    ttmc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign sense    = s_tdata[11:0];
    assign pot      = s_tdata[23:12];
    assign thr_up   = cfg.threshold_max >= cfg.threshold_min;
    assign thr_diff = thr_up ? (cfg.threshold_max - cfg.threshold_min)
                             : (cfg.threshold_min - cfg.threshold_max);
    assign thr_prod = 28'(pot) * 28'(thr_diff);
    assign thr_step = thr_prod[ADC_BITS+15:ADC_BITS];
    assign ith_calc = thr_up ? (cfg.threshold_min + thr_step)
                             : (cfg.threshold_min - thr_step);

    assign q_off    = div_q - DIV_Q_W'(128);
    assign raw_est  = hold_reg ? filt_reg :
                      (div_q < DIV_Q_W'(128)) ? 16'd0 :
                      (q_off > DIV_Q_W'(65535)) ? 16'hFFFF : q_off[15:0];
    assign filt_sum = 18'(filt_reg) * 18'd3 + 18'(raw_est);

    assign five_f      = 19'(filt_reg) * 19'd5;
    assign four_ith    = 19'(ith_reg) * 19'd4;
    assign three_ith   = 19'(ith_reg) * 19'd3;
    assign gap         = ith_reg - filt_reg;
    assign fifty_gap   = 22'(gap) * 22'd50;
    assign three_ith_w = 22'(ith_reg) * 22'd3;
    assign soft_num    = 31'(gap) * 31'(SOFT_K);
    assign pt_inc      = (phase_reg == 16'hFFFF) ? phase_reg : phase_reg + 16'd1;
    assign ramp_num    = 29'(pt_inc) * 29'(DUTY_WRAP);
    assign hcnt_inc    = (hcnt_reg == 16'hFFFF) ? hcnt_reg : hcnt_reg + 16'd1;
    assign over_inc    = (over_reg == 8'hFF) ? over_reg : over_reg + 8'd1;
    assign over_new    = (filt_reg >= ith_reg) ? over_inc : 8'd0;
    assign slope_diff  = {2'b00, filt_reg} - {2'b00, hist_reg[pos_reg]};
    assign slope_hit   = $signed(slope_diff) >= $signed({2'b00, cfg.slope_trip});

    assign awake = (mode_reg >= MODE_START && mode_reg <= MODE_STOPPING) || fentry_reg;

    always_comb
    begin
        st_next      = st_reg;
        p1_next      = p1_reg;
        ith_next     = ith_reg;
        flt_next     = flt_reg;
        hold_next    = hold_reg;
        mode_next    = mode_reg;
        filt_next    = filt_reg;
        hist_next    = hist_reg;
        pos_next     = pos_reg;
        over_next    = over_reg;
        hcnt_next    = hcnt_reg;
        phase_next   = phase_reg;
        duty_next    = duty_reg;
        dirl_next    = dirl_reg;
        dirp_next    = dirp_reg;
        reason_next  = reason_reg;
        fentry_next  = fentry_reg;
        mval_next    = mval_reg;
        mdata_next   = mdata_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        dp           = dirp_reg;
        do_soft      = 1'b0;

        if (mval_reg && m_tready)
        begin
            mval_next = 1'b0;
        end

        case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    flt_next = s_tdata[27];
                    p1_next  = 25'(sense) * 25'(DUTY_WRAP);
                    ith_next = ith_calc;
                    st_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (17'(duty_reg) * 17'd10 < 17'(DUTY_WRAP))
                begin
                    hold_next = 1'b1;
                    st_next   = ST_FILT;
                end
                else
                begin
                    hold_next    = 1'b0;
                    div_start    = 1'b1;
                    div_dividend = DIV_N_W'(p1_reg) * DIV_N_W'(NUM_K);
                    div_divisor  = DIV_D_W'(duty_reg) * DIV_D_W'(DEN_K);
                    st_next      = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    st_next = ST_FILT;
                end
            end
            ST_FILT:
            begin
                filt_next          = filt_sum[17:2];
                hist_next[pos_reg] = filt_sum[17:2];
                pos_next = (pos_reg == POS_W'(HISTORY_DEPTH_P - 1)) ? '0 : pos_reg + 1'b1;
                st_next  = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                st_next     = ST_OUT;
                reason_next = TRIP_NONE;
                fentry_next = 1'b0;
                if (mode_reg == MODE_IDLE || mode_reg == MODE_STOPPED ||
                    mode_reg == MODE_FAULT)
                begin
                    if (stable[1] && !stable[2])
                    begin
                        dp = 1'b1;
                    end
                    else if (stable[2] && !stable[1])
                    begin
                        dp = 1'b0;
                    end
                end
                dirp_next = dp;

                if (flt_reg && mode_reg != MODE_FAULT)
                begin
                    duty_next   = '0;
                    hcnt_next   = '0;
                    mode_next   = MODE_FAULT;
                    reason_next = TRIP_DRIVER;
                    fentry_next = 1'b1;
                end
                else
                begin
                    case (mode_reg)
                        MODE_IDLE:
                        begin
                            if (bt)
                            begin
                                dirl_next  = dp;
                                duty_next  = '0;
                                filt_next  = '0;
                                for (int k = 0; k < HISTORY_DEPTH_P; k++)
                                begin
                                    hist_next[k] = '0;
                                end
                                over_next  = '0;
                                phase_next = '0;
                                mode_next  = MODE_START;
                            end
                        end
                        MODE_START:
                        begin
                            if (!bt || filt_reg >= cfg.hard_limit)
                            begin
                                duty_next  = '0;
                                phase_next = '0;
                                mode_next  = MODE_STOPPING;
                                if (bt)
                                begin
                                    reason_next = TRIP_HARD;
                                end
                            end
                            else if (pt_inc >= cfg.soft_start_ticks)
                            begin
                                phase_next = pt_inc;
                                duty_next  = DUTY_W'(DUTY_WRAP);
                                mode_next  = MODE_RUN;
                            end
                            else
                            begin
                                phase_next   = pt_inc;
                                div_start    = 1'b1;
                                div_dividend = DIV_N_W'(ramp_num);
                                div_divisor  = DIV_D_W'(cfg.soft_start_ticks);
                                st_next      = ST_DIV2;
                            end
                        end
                        MODE_RUN, MODE_DITHER:
                        begin
                            if (!bt)
                            begin
                                duty_next  = '0;
                                phase_next = '0;
                                mode_next  = MODE_STOPPING;
                            end
                            else if (filt_reg >= cfg.hard_limit)
                            begin
                                duty_next   = '0;
                                phase_next  = '0;
                                mode_next   = MODE_STOPPING;
                                reason_next = TRIP_HARD;
                            end
                            else
                            begin
                                over_next = over_new;
                                if (filt_reg >= ith_reg && over_new >= cfg.confirm_ticks)
                                begin
                                    duty_next   = '0;
                                    phase_next  = '0;
                                    mode_next   = MODE_STOPPING;
                                    reason_next = TRIP_OVER;
                                end
                                else if (slope_hit)
                                begin
                                    duty_next   = '0;
                                    phase_next  = '0;
                                    mode_next   = MODE_STOPPING;
                                    reason_next = TRIP_SLOPE;
                                end
                                else if (mode_reg == MODE_RUN)
                                begin
                                    if (five_f > four_ith)
                                    begin
                                        mode_next = MODE_DITHER;
                                        do_soft   = 1'b1;
                                    end
                                    else
                                    begin
                                        duty_next = DUTY_W'(DUTY_WRAP);
                                    end
                                end
                                else if (five_f < three_ith)
                                begin
                                    mode_next = MODE_RUN;
                                    duty_next = DUTY_W'(DUTY_WRAP);
                                end
                                else
                                begin
                                    do_soft = 1'b1;
                                end
                            end
                            if (do_soft)
                            begin
                                if (five_f <= four_ith)
                                begin
                                    duty_next = DUTY_W'(DUTY_WRAP);
                                end
                                else if (filt_reg >= ith_reg || fifty_gap < three_ith_w)
                                begin
                                    duty_next = DUTY_W'(DUTY_MIN_DITHER);
                                end
                                else
                                begin
                                    div_start    = 1'b1;
                                    div_dividend = DIV_N_W'(soft_num);
                                    div_divisor  = DIV_D_W'(ith_reg);
                                    st_next      = ST_DIV2;
                                end
                            end
                        end
                        MODE_STOPPING:
                        begin
                            phase_next = pt_inc;
                            if (pt_inc >= cfg.cooldown_ticks)
                            begin
                                duty_next = '0;
                                mode_next = MODE_STOPPED;
                            end
                        end
                        MODE_STOPPED:
                        begin
                            if (!bt)
                            begin
                                mode_next = MODE_IDLE;
                            end
                        end
                        MODE_FAULT:
                        begin
                            duty_next = '0;
                            if (!flt_reg)
                            begin
                                hcnt_next = hcnt_inc;
                                if (hcnt_inc >= cfg.fault_holdoff_ticks && !bt)
                                begin
                                    hcnt_next = '0;
                                    mode_next = MODE_IDLE;
                                end
                            end
                            else
                            begin
                                hcnt_next = '0;
                            end
                        end
                        default:
                        begin
                            duty_next = '0;
                            mode_next = MODE_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV2:
            begin
                if (div_done)
                begin
                    duty_next = div_q[DUTY_W-1:0];
                    st_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                mval_next  = 1'b1;
                mdata_next = {3'b000, ith_reg, filt_reg, reason_reg, awake, dirl_reg,
                              duty_reg, mode_reg};
                st_next    = ST_IDLE;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            mode_reg   <= MODE_IDLE;
            filt_reg   <= '0;
            for (int k = 0; k < HISTORY_DEPTH_P; k++)
            begin
                hist_reg[k] <= '0;
            end
            pos_reg    <= '0;
            over_reg   <= '0;
            hcnt_reg   <= '0;
            phase_reg  <= '0;
            duty_reg   <= '0;
            dirl_reg   <= 1'b1;
            dirp_reg   <= 1'b1;
            reason_reg <= TRIP_NONE;
            fentry_reg <= 1'b0;
            mval_reg   <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            mode_reg   <= mode_next;
            filt_reg   <= filt_next;
            hist_reg   <= hist_next;
            pos_reg    <= pos_next;
            over_reg   <= over_next;
            hcnt_reg   <= hcnt_next;
            phase_reg  <= phase_next;
            duty_reg   <= duty_next;
            dirl_reg   <= dirl_next;
            dirp_reg   <= dirp_next;
            reason_reg <= reason_next;
            fentry_reg <= fentry_next;
            mval_reg   <= mval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg    <= p1_next;
        ith_reg   <= ith_next;
        flt_reg   <= flt_next;
        hold_reg  <= hold_next;
        mdata_reg <= mdata_next;
    end

endmodule
